FILE: hdl/hsvrgb_pkg.sv
package hsvrgb_pkg;

  // Pipeline depth, counted from the input register to the output register.
  localparam int unsigned NSTAGE = 6;
  localparam int unsigned FRONT_STAGES = 2;

  localparam int unsigned PCT_W = 7;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
  localparam int unsigned CH_W = 8;
  localparam int unsigned V255_W = 15;

  // Every channel is floor(255 * v * n / (600000 * 2^F)). Once the F fraction
  // bits have been shifted out, the numerator fits in X_W bits and the division
  // by 600000 becomes a reciprocal multiply followed by one correction step.
  localparam int unsigned X_W = 28;
  localparam int unsigned DIV_W = 20;
  localparam logic [DIV_W-1:0] DIV_DEN = 20'd600000;
  localparam int unsigned DIV_SHIFT = 28;
  localparam int unsigned RECIP_W = 9;
  localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / 64'd600000);

endpackage

FILE: hdl/hsvrgb_front.sv
module hsvrgb_front #(
  parameter int unsigned HUE_FRAC_BITS = 7
) (
  input  logic                               clk,
  input  logic [hsvrgb_pkg::FRONT_STAGES-1:0] adv,
  input  logic [15:0]                        hue,
  input  logic [hsvrgb_pkg::PCT_W-1:0]       saturation,
  input  logic [hsvrgb_pkg::PCT_W-1:0]       brightness,
  output logic [HUE_FRAC_BITS+5:0]           d_red,
  output logic [HUE_FRAC_BITS+5:0]           d_green,
  output logic [HUE_FRAC_BITS+5:0]           d_blue,
  output logic [hsvrgb_pkg::PCT_W-1:0]       sat_out,
  output logic [hsvrgb_pkg::V255_W-1:0]      v255_out
);

  localparam int unsigned PW = HUE_FRAC_BITS + 6;
  localparam logic [31:0] P_CODE = 32'(60 * (2 ** HUE_FRAC_BITS));
  localparam logic [31:0] HUE_MAX = 32'(6 * P_CODE - 1);

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  logic [31:0]                  h_clamp;
  sector_t                      sec_nxt;
  logic [hsvrgb_pkg::PCT_W-1:0] s_nxt, v_nxt;

  logic [15:0]                  h0_r;
  sector_t                      sec0_r;
  logic [hsvrgb_pkg::PCT_W-1:0] s0_r, v0_r;

  logic [31:0]                  base, t, hdist32;
  logic [PW-1:0]                hdist, pfull;
  logic [PW-1:0]                dr_nxt, dg_nxt, db_nxt;
  logic [hsvrgb_pkg::V255_W-1:0] v255_nxt;

  logic [PW-1:0]                dr_r, dg_r, db_r;
  logic [hsvrgb_pkg::PCT_W-1:0] s1_r;
  logic [hsvrgb_pkg::V255_W-1:0] v255_r;

  // Stage 0: saturate the inputs and find the 60-degree sector.
  always_comb begin
    h_clamp = (32'(hue) > HUE_MAX) ? HUE_MAX : 32'(hue);
    if (h_clamp >= 32'(5 * P_CODE)) begin
      sec_nxt = SEC_MR;
    end else if (h_clamp >= 32'(4 * P_CODE)) begin
      sec_nxt = SEC_BM;
    end else if (h_clamp >= 32'(3 * P_CODE)) begin
      sec_nxt = SEC_CB;
    end else if (h_clamp >= 32'(2 * P_CODE)) begin
      sec_nxt = SEC_GC;
    end else if (h_clamp >= P_CODE) begin
      sec_nxt = SEC_YG;
    end else begin
      sec_nxt = SEC_RY;
    end
    s_nxt = (saturation > hsvrgb_pkg::PCT_MAX) ? hsvrgb_pkg::PCT_MAX : saturation;
    v_nxt = (brightness > hsvrgb_pkg::PCT_MAX) ? hsvrgb_pkg::PCT_MAX : brightness;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      h0_r   <= h_clamp[15:0];
      sec0_r <= sec_nxt;
      s0_r   <= s_nxt;
      v0_r   <= v_nxt;
    end
  end

  // Stage 1: distance of the hue from the centre of its 120-degree pair. Each
  // channel then gets the amount to take off its full level: none for the
  // leading channel, the distance for the secondary one, a whole sector for
  // the trailing one.
  always_comb begin
    case (sec0_r) inside
      SEC_RY, SEC_YG: base = 32'd0;
      SEC_GC, SEC_CB: base = 32'(2 * P_CODE);
      default:        base = 32'(4 * P_CODE);
    endcase
    t       = 32'(h0_r) - base;
    hdist32 = (t >= P_CODE) ? (t - P_CODE) : (P_CODE - t);
    hdist   = hdist32[PW-1:0];
    pfull   = P_CODE[PW-1:0];
    unique case (sec0_r)
      SEC_RY:  begin dr_nxt = '0;    dg_nxt = hdist; db_nxt = pfull; end
      SEC_YG:  begin dr_nxt = hdist; dg_nxt = '0;    db_nxt = pfull; end
      SEC_GC:  begin dr_nxt = pfull; dg_nxt = '0;    db_nxt = hdist; end
      SEC_CB:  begin dr_nxt = pfull; dg_nxt = hdist; db_nxt = '0;    end
      SEC_BM:  begin dr_nxt = hdist; dg_nxt = pfull; db_nxt = '0;    end
      default: begin dr_nxt = '0;    dg_nxt = pfull; db_nxt = hdist; end
    endcase
    v255_nxt = (hsvrgb_pkg::V255_W'(v0_r) << 8) - hsvrgb_pkg::V255_W'(v0_r);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      dr_r   <= dr_nxt;
      dg_r   <= dg_nxt;
      db_r   <= db_nxt;
      s1_r   <= s0_r;
      v255_r <= v255_nxt;
    end
  end

  assign d_red    = dr_r;
  assign d_green  = dg_r;
  assign d_blue   = db_r;
  assign sat_out  = s1_r;
  assign v255_out = v255_r;

endmodule

FILE: hdl/hsvrgb_chan.sv
module hsvrgb_chan #(
  parameter int unsigned HUE_FRAC_BITS = 7
) (
  input  logic                              clk,
  input  logic [3:0]                        adv,
  input  logic [HUE_FRAC_BITS+5:0]          d,
  input  logic [hsvrgb_pkg::PCT_W-1:0]      sat,
  input  logic [hsvrgb_pkg::V255_W-1:0]     v255,
  output logic [hsvrgb_pkg::CH_W-1:0]       level
);

  localparam int unsigned NW   = HUE_FRAC_BITS + 13;
  localparam int unsigned XF_W = hsvrgb_pkg::V255_W + NW;
  localparam int unsigned QP_W = hsvrgb_pkg::X_W + hsvrgb_pkg::RECIP_W;
  localparam logic [NW-1:0] HUND_P = NW'(6000 * (2 ** HUE_FRAC_BITS));

  logic [NW-1:0]                       sd, n_nxt, n_r;
  logic [hsvrgb_pkg::V255_W-1:0]       v2_r;
  logic [XF_W-1:0]                     x_full;
  logic [hsvrgb_pkg::X_W-1:0]          x3_r, x4_r;
  logic [QP_W-1:0]                     qp;
  logic [hsvrgb_pkg::RECIP_W-1:0]      q0_r;
  logic [hsvrgb_pkg::X_W-1:0]          qd, rem;
  logic [hsvrgb_pkg::CH_W-1:0]         level_nxt, level_r;

  // Stage 2: numerator factor 100p - s*d.
  assign sd    = NW'(sat) * NW'(d);
  assign n_nxt = HUND_P - sd;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      n_r  <= n_nxt;
      v2_r <= v255;
    end
  end

  // Stage 3: full product, with the hue fraction bits dropped.
  assign x_full = XF_W'(v2_r) * XF_W'(n_r);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      x3_r <= x_full[HUE_FRAC_BITS +: hsvrgb_pkg::X_W];
    end
  end

  // Stage 4: quotient estimate, which is exact or one short.
  assign qp = QP_W'(x3_r) * QP_W'(hsvrgb_pkg::DIV_RECIP);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      q0_r <= qp[QP_W-1:hsvrgb_pkg::DIV_SHIFT];
      x4_r <= x3_r;
    end
  end

  // Stage 5: correct the estimate from the remainder.
  always_comb begin
    qd  = hsvrgb_pkg::X_W'(q0_r) * hsvrgb_pkg::X_W'(hsvrgb_pkg::DIV_DEN);
    rem = x4_r - qd;
    level_nxt = hsvrgb_pkg::CH_W'(q0_r + hsvrgb_pkg::RECIP_W'(
                  rem >= hsvrgb_pkg::X_W'(hsvrgb_pkg::DIV_DEN)));
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

endmodule

FILE: hdl/hsv_to_rgb_unit.sv
// Channel  Dir  Beat contents
// in_      in   hue, saturation, brightness (HSV pixel)
// out_     out  red, green, blue (8-bit RGB pixel)
//
// Six register stages; a pixel passes through all six before it leaves, and
// one pixel can be taken in every cycle unless a stalled output has filled every stage.
// Each stage moves on when it is empty or the stage after it moves, so empty
// stages close up behind a stalled output and input beats are still taken.
// Synchronous reset clears only the stage valid bits.
module hsv_to_rgb_unit #(
  parameter int unsigned HUE_FRAC_BITS = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // hue[15:0], saturation[22:16], brightness[29:23], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  localparam int unsigned NSTAGE = hsvrgb_pkg::NSTAGE;
  localparam int unsigned FS     = hsvrgb_pkg::FRONT_STAGES;
  localparam int unsigned PW     = HUE_FRAC_BITS + 6;

  logic [NSTAGE-1:0] v_r, v_nxt, adv;

  logic [PW-1:0]                         d_red, d_green, d_blue;
  logic [hsvrgb_pkg::PCT_W-1:0]          sat1;
  logic [hsvrgb_pkg::V255_W-1:0]         v255;
  logic [hsvrgb_pkg::CH_W-1:0]           red, green, blue;

  always_comb begin
    adv[NSTAGE-1] = !v_r[NSTAGE-1] || out_tready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
    if (adv[0]) begin
      v_nxt[0] = in_tvalid;
    end else begin
      v_nxt[0] = v_r[0];
    end
    for (int i = 1; i < NSTAGE; i++) begin
      if (adv[i]) begin
        v_nxt[i] = v_r[i-1];
      end else begin
        v_nxt[i] = v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = v_r[NSTAGE-1];
  assign out_tdata  = {blue, green, red};

  hsvrgb_front #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .adv       (adv[FS-1:0]),
    .hue       (in_tdata[15:0]),
    .saturation(in_tdata[22:16]),
    .brightness(in_tdata[29:23]),
    .d_red     (d_red),
    .d_green   (d_green),
    .d_blue    (d_blue),
    .sat_out   (sat1),
    .v255_out  (v255)
  );

  hsvrgb_chan #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_chan_red (
    .clk  (clk),
    .adv  (adv[NSTAGE-1:FS]),
    .d    (d_red),
    .sat  (sat1),
    .v255 (v255),
    .level(red)
  );

  hsvrgb_chan #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_chan_green (
    .clk  (clk),
    .adv  (adv[NSTAGE-1:FS]),
    .d    (d_green),
    .sat  (sat1),
    .v255 (v255),
    .level(green)
  );

  hsvrgb_chan #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_chan_blue (
    .clk  (clk),
    .adv  (adv[NSTAGE-1:FS]),
    .d    (d_blue),
    .sat  (sat1),
    .v255 (v255),
    .level(blue)
  );

  a_take_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted beat did not reach the first stage");

  a_mid_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] && !adv[2] |=> v_r[2])
    else $error("stalled pixel dropped from a middle stage");

  a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!(&v_r) || out_tready))
    else $error("input taken with a full pipeline and a stalled output");

endmodule
